FILE: rtl/kale_pkg.sv
// Shared types and constants of the keyed array list engine.
`default_nettype none

package kale_pkg;

    localparam int KEY_W   = 32;
    localparam int GRADE_W = 16;
    localparam int AVG_W   = 17;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 3;

    typedef enum logic [1:0] {
        OP_INS_CHECKED   = 2'd0,
        OP_INS_UNCHECKED = 2'd1,
        OP_REMOVE        = 2'd2,
        OP_SEARCH        = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_MISSING = 3'd4
    } status_t;

    // One stored record: key, both grades and their sum read with 9 fraction bits.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [GRADE_W-1:0] one;
        logic [GRADE_W-1:0] two;
        logic [AVG_W-1:0]   avg;
    } record_t;

    // A classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic    is_insert;
        logic    check_dup;
        logic    is_remove;
        record_t rec;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/kale_intf.sv
// Request and response channel interfaces of the keyed array list engine.
`default_nettype none

interface kale_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             opcode;
    logic signed [kale_pkg::KEY_W-1:0]      key;
    logic [kale_pkg::GRADE_W-1:0]           grade_one;
    logic [kale_pkg::GRADE_W-1:0]           grade_two;

    modport source (output valid, opcode, key, grade_one, grade_two, input ready);
    modport sink   (input valid, opcode, key, grade_one, grade_two, output ready);
endinterface

interface kale_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [kale_pkg::STAT_W-1:0]            status;
    logic [kale_pkg::SLOT_W-1:0]            slot;
    logic signed [kale_pkg::KEY_W-1:0]      found_key;
    logic [kale_pkg::GRADE_W-1:0]           found_one;
    logic [kale_pkg::GRADE_W-1:0]           found_two;
    logic [kale_pkg::AVG_W-1:0]             found_average;
    logic [kale_pkg::COUNT_W-1:0]           entry_count;
    logic                                   is_empty;
    logic                                   is_full;

    modport source (output valid, status, slot, found_key, found_one, found_two,
                    found_average, entry_count, is_empty, is_full, input ready);
    modport sink   (input valid, status, slot, found_key, found_one, found_two,
                    found_average, entry_count, is_empty, is_full, output ready);
endinterface

`default_nettype wire

FILE: rtl/kale_front.sv
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
`default_nettype none

module kale_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    kale_req_if.sink          req,
    output kale_pkg::cmd_t    cmd,
    output logic              cmd_valid,
    input  wire logic         cmd_pop
);

    kale_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push;
    kale_pkg::cmd_t new_cmd;

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd           = '0;
        new_cmd.rec.key   = req.key;
        new_cmd.rec.one   = req.grade_one;
        new_cmd.rec.two   = req.grade_two;
        // The average is the exact sum, read with one more fraction bit.
        new_cmd.rec.avg   = kale_pkg::AVG_W'(req.grade_one) + kale_pkg::AVG_W'(req.grade_two);
        unique case (kale_pkg::opcode_t'(req.opcode))
            kale_pkg::OP_INS_CHECKED:
            begin
                new_cmd.is_insert = 1'b1;
                new_cmd.check_dup = 1'b1;
            end
            kale_pkg::OP_INS_UNCHECKED:
            begin
                new_cmd.is_insert = 1'b1;
            end
            kale_pkg::OP_REMOVE:
            begin
                new_cmd.is_remove = 1'b1;
            end
            default:
            begin
                new_cmd.is_insert = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kale_back.sv
// Back end: record memory, key scan, swap-remove and the response register.
`default_nettype none

module kale_back #(
    parameter int CAPACITY = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire kale_pkg::cmd_t  cmd,
    input  wire logic            cmd_valid,
    output logic                 cmd_pop,
    kale_rsp_if.source           rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_MOVE = 3'b100
    } state_t;

    typedef struct packed {
        kale_pkg::status_t             status;
        logic [kale_pkg::SLOT_W-1:0]   slot;
        kale_pkg::record_t             rec;
        logic [kale_pkg::COUNT_W-1:0]  entry_count;
        logic                          is_empty;
        logic                          is_full;
    } result_t;

    kale_pkg::record_t mem [CAPACITY];
    kale_pkg::record_t rd_data_reg;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]     issue_reg, issue_next;
    kale_pkg::cmd_t    cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;
    logic              res_load;

    logic              res_free;
    logic [CW-1:0]     last;
    logic              match;
    logic              at_end;
    logic              is_full_now;
    logic [IW-1:0]     rd_addr;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    kale_pkg::record_t mem_wdata;

    assign res_free    = !out_valid_reg || rsp.ready;
    assign cmd_pop     = (state_reg == S_IDLE) && cmd_valid && res_free;
    assign last        = count_reg - CW'(1);
    assign match       = (rd_data_reg.key == cur_reg.rec.key);
    assign at_end      = (cmp_idx_reg == last);
    assign is_full_now = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmp_idx_next   = cmp_idx_reg;
        issue_next     = issue_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        res_load       = 1'b0;
        res_next       = '0;
        rd_addr        = issue_reg[IW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IW-1:0];
        mem_wdata      = cur_reg.rec;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (cmd_pop)
                begin
                    cur_next     = cmd;
                    cmp_idx_next = '0;
                    issue_next   = CW'(1);
                    res_load     = 1'b1;
                    if (cmd.is_insert)
                    begin
                        if (is_full_now)
                        begin
                            res_next.status = kale_pkg::ST_FULL;
                        end
                        else if (!cmd.check_dup || count_reg == '0)
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = cmd.rec;
                            count_next      = count_reg + CW'(1);
                            res_next.status = kale_pkg::ST_OK;
                            res_next.slot   = kale_pkg::SLOT_W'(count_reg);
                        end
                        else
                        begin
                            res_load   = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = kale_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_load   = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Reads run one slot ahead of the compare.
                issue_next   = issue_reg + CW'(1);
                cmp_idx_next = cmp_idx_reg + CW'(1);
                if (match)
                begin
                    cmp_idx_next = cmp_idx_reg;
                    if (cur_reg.is_insert)
                    begin
                        res_load        = 1'b1;
                        res_next.status = kale_pkg::ST_DUP;
                        res_next.slot   = kale_pkg::SLOT_W'(cmp_idx_reg);
                        state_next      = S_IDLE;
                    end
                    else if (cur_reg.is_remove)
                    begin
                        rd_addr    = last[IW-1:0];
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        res_load        = 1'b1;
                        res_next.status = kale_pkg::ST_OK;
                        res_next.slot   = kale_pkg::SLOT_W'(cmp_idx_reg);
                        res_next.rec    = rd_data_reg;
                        state_next      = S_IDLE;
                    end
                end
                else if (at_end)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (cur_reg.is_insert)
                    begin
                        mem_we          = 1'b1;
                        count_next      = count_reg + CW'(1);
                        res_next.status = kale_pkg::ST_OK;
                        res_next.slot   = kale_pkg::SLOT_W'(count_reg);
                    end
                    else
                    begin
                        res_next.status = kale_pkg::ST_MISSING;
                    end
                end
            end
            S_MOVE:
            begin
                // The last record refills the freed slot; removing the last one rewrites itself.
                mem_we          = 1'b1;
                mem_waddr       = cmp_idx_reg[IW-1:0];
                mem_wdata       = rd_data_reg;
                count_next      = last;
                res_load        = 1'b1;
                res_next.status = kale_pkg::ST_OK;
                res_next.slot   = kale_pkg::SLOT_W'(cmp_idx_reg);
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.entry_count = kale_pkg::COUNT_W'(count_next);
        res_next.is_empty    = (count_next == '0);
        res_next.is_full     = (count_next == CW'(CAPACITY));
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        issue_reg   <= issue_next;
        cur_reg     <= cur_next;
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = res_reg.status;
    assign rsp.slot          = res_reg.slot;
    assign rsp.found_key     = res_reg.rec.key;
    assign rsp.found_one     = res_reg.rec.one;
    assign rsp.found_two     = res_reg.rec.two;
    assign rsp.found_average = res_reg.rec.avg;
    assign rsp.entry_count   = res_reg.entry_count;
    assign rsp.is_empty      = res_reg.is_empty;
    assign rsp.is_full       = res_reg.is_full;

endmodule

`default_nettype wire

FILE: rtl/keyed_array_list_engine_unit.sv
// Keyed array list engine: unordered record table with swap-remove.
// A request is registered in the front queue; the back end takes it only when idle.
// Rejections and unchecked inserts are answered from the idle state without a scan;
// search, remove and checked insert scan the stored keys one per cycle through the
// single memory read port; a remove then moves the last record into the freed slot.
// Reset clears the record count and the queue; the record memory is not cleared.
`default_nettype none

module keyed_array_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kale_req_if.sink   req,
    kale_rsp_if.source rsp
);

    kale_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    kale_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    kale_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

FILE: rtl/kale_chk.sv
// Port-level checker for the keyed array list engine and its bind.
`default_nettype none

module kale_chk #(
    parameter int CAPACITY = 16
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [kale_pkg::STAT_W-1:0]       status,
    input wire logic [kale_pkg::KEY_W-1:0]        found_key,
    input wire logic [kale_pkg::GRADE_W-1:0]      found_one,
    input wire logic [kale_pkg::GRADE_W-1:0]      found_two,
    input wire logic [kale_pkg::AVG_W-1:0]        found_average,
    input wire logic [kale_pkg::COUNT_W-1:0]      entry_count,
    input wire logic                              is_empty,
    input wire logic                              is_full
);

    // A stalled response must stay put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count))
        else $error("response changed while stalled");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> entry_count == '0)
        else $error("empty flag with nonzero count");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == kale_pkg::ST_FULL |-> is_full && !is_empty)
        else $error("full rejection while table not full");

    // Only a successful search returns record contents.
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != kale_pkg::ST_OK |->
            found_key == '0 && found_one == '0 && found_two == '0 && found_average == '0)
        else $error("record fields set on a failed request");

endmodule

bind keyed_array_list_engine_unit kale_chk #(
    .CAPACITY (CAPACITY)
) u_kale_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .found_key     (rsp.found_key),
    .found_one     (rsp.found_one),
    .found_two     (rsp.found_two),
    .found_average (rsp.found_average),
    .entry_count   (rsp.entry_count),
    .is_empty      (rsp.is_empty),
    .is_full       (rsp.is_full)
);

`default_nettype wire
